FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/ndem_pkg.sv
// ----------------------------------------------------------------------------
// ndem_pkg
// Shared types and constants of the neighbour difference edge marker.
// ----------------------------------------------------------------------------
package ndem_pkg;

  // Sizes
  localparam int MAX_WIDTH  = 2048;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 12;
  localparam int THR_W      = 8;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int WIN_N      = 9;
  localparam int WIN_CTR    = 4;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [THR_W-1:0]  thr_t;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_DIFF_THRESHOLD = 2'd2
  } cfg_reg_e;

  // Reset values and limits
  localparam dim_t RESET_WIDTH     = 12'd640;
  localparam dim_t RESET_HEIGHT    = 12'd480;
  localparam thr_t RESET_THRESHOLD = 8'd100;
  localparam dim_t MIN_DIM         = 12'd3;
  localparam dim_t MAX_WIDTH_DIM   = DIM_W'(MAX_WIDTH);

  // Marker values
  localparam pix_t EDGE_ON  = 8'd255;
  localparam pix_t EDGE_OFF = 8'd0;

  // One line buffer word: the two rows above the current one
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_word_t;

  // Line buffer write request
  typedef struct packed {
    logic       en;
    addr_t      addr;
    line_word_t data;
  } line_wr_t;

  // Line buffer read request
  typedef struct packed {
    logic  en;
    addr_t addr;
  } line_rd_t;

endpackage

FILE: rtl/ndem_line_ram.sv
// ----------------------------------------------------------------------------
// ndem_line_ram
// Two-row line buffer: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ndem_line_ram (
  input  logic                clk_i,
  input  ndem_pkg::line_wr_t  wr_i,
  input  ndem_pkg::line_rd_t  rd_i,
  output ndem_pkg::line_word_t rdata_o
);

  ndem_pkg::line_word_t mem [ndem_pkg::MAX_WIDTH];
  ndem_pkg::line_word_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ndem_edge_cmp.sv
// ----------------------------------------------------------------------------
// ndem_edge_cmp
// Compares the window centre with its eight neighbours against a threshold.
// ----------------------------------------------------------------------------
module ndem_edge_cmp (
  input  ndem_pkg::pix_t [ndem_pkg::WIN_N-1:0] win_i,
  input  ndem_pkg::thr_t                       thr_i,
  output logic                                 edge_o
);

  ndem_pkg::pix_t                 ctr;
  logic [ndem_pkg::WIN_N-1:0]     hit;

  assign ctr = win_i[ndem_pkg::WIN_CTR];

  // Absolute difference per neighbour, centre excluded
  always_comb begin
    for (int k = 0; k < ndem_pkg::WIN_N; k++) begin
      ndem_pkg::pix_t d;
      d = (win_i[k] > ctr) ? (win_i[k] - ctr) : (ctr - win_i[k]);
      hit[k] = (k != ndem_pkg::WIN_CTR) && (d > thr_i);
    end
  end

  assign edge_o = |hit;

endmodule

FILE: rtl/neighbor_difference_edge_marker_top.sv
// ----------------------------------------------------------------------------
// neighbor_difference_edge_marker_top
// 3x3 neighbour difference edge marker over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless a waiting result holds stage 1. On
// transfer the pixel enters stage 1 and its column addresses the line buffer
// (one 2048 x 16 RAM holding both previous rows); the registered read arrives
// in the next cycle, where the 3x3 window is compared, and the RAM column is
// written back when the pixel leaves stage 1. The mark of an interior pixel
// is loaded into the result register as it leaves stage 1 and is offered
// from then on. The result register decouples the output: a waiting result
// lets one more pixel into stage 1, and input then waits only if that pixel
// is interior too. Interior pixels only give a result; frame_done marks the
// last one of a frame. Width is clamped to 3..2048 and height to at least 3;
// register writes are for idle periods.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module neighbor_difference_edge_marker_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration
  input  logic                                cfg_we_i,
  input  logic [ndem_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ndem_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Pixel input
  input  logic                                pixel_valid_i,
  output logic                                pixel_ready_o,
  input  ndem_pkg::pix_t                      pixel_i,
  // Result output
  output logic                                result_valid_o,
  input  logic                                result_ready_i,
  output ndem_pkg::pix_t                      edge_mark_o,
  output logic                                frame_done_o
);

  // Configuration registers
  ndem_pkg::dim_t width_q, height_q;
  ndem_pkg::thr_t thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ndem_pkg::RESET_WIDTH;
      height_q <= ndem_pkg::RESET_HEIGHT;
      thr_q    <= ndem_pkg::RESET_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (ndem_pkg::cfg_reg_e'(cfg_index_i))
        ndem_pkg::REG_IMAGE_WIDTH:    width_q  <= cfg_data_i;
        ndem_pkg::REG_IMAGE_HEIGHT:   height_q <= cfg_data_i;
        ndem_pkg::REG_DIFF_THRESHOLD: thr_q    <= cfg_data_i[ndem_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size
  ndem_pkg::dim_t w_eff, h_eff;

  assign w_eff = (width_q < ndem_pkg::MIN_DIM)       ? ndem_pkg::MIN_DIM :
                 (width_q > ndem_pkg::MAX_WIDTH_DIM) ? ndem_pkg::MAX_WIDTH_DIM : width_q;
  assign h_eff = (height_q < ndem_pkg::MIN_DIM) ? ndem_pkg::MIN_DIM : height_q;

  // Handshake and pipeline control
  logic in_fire, s1_adv, out_fire;
  logic s1_valid_q, out_valid_q;
  logic s1_prod_q, s1_frame_q;
  ndem_pkg::pix_t s1_pix_q;
  ndem_pkg::addr_t s1_col_q;

  assign in_fire  = pixel_valid_i & pixel_ready_o;
  assign out_fire = out_valid_q & result_ready_i;
  assign s1_adv   = s1_valid_q & (~s1_prod_q | ~out_valid_q | result_ready_i);
  assign pixel_ready_o = ~s1_valid_q | s1_adv;

  // Position counters
  ndem_pkg::addr_t col_q, col_d;
  ndem_pkg::dim_t  row_q, row_d;
  ndem_pkg::dim_t  col_inc;
  logic [ndem_pkg::DIM_W:0] row_inc;
  logic row_end, frame_end, interior;

  assign col_inc   = {1'b0, col_q} + ndem_pkg::DIM_W'(1);
  assign row_inc   = {1'b0, row_q} + (ndem_pkg::DIM_W + 1)'(1);
  assign row_end   = (col_inc >= w_eff);
  assign frame_end = row_end && (row_inc >= {1'b0, h_eff});
  assign interior  = (col_q >= ndem_pkg::ADDR_W'(2)) && (row_q >= ndem_pkg::DIM_W'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_inc[ndem_pkg::DIM_W-1:0];
      end else begin
        col_d = col_inc[ndem_pkg::ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Input register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pixel_ready_o) begin
      s1_valid_q <= pixel_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q   <= pixel_i;
      s1_col_q   <= col_q;
      s1_prod_q  <= interior;
      s1_frame_q <= frame_end;
    end
  end

  // Line buffer: read on transfer, write back when the item leaves stage 1
  ndem_pkg::line_wr_t   line_wr;
  ndem_pkg::line_rd_t   line_rd;
  ndem_pkg::line_word_t line_rdata;

  assign line_rd.en          = in_fire;
  assign line_rd.addr        = col_q;
  assign line_wr.en          = s1_adv;
  assign line_wr.addr        = s1_col_q;
  assign line_wr.data.upper  = line_rdata.middle;
  assign line_wr.data.middle = s1_pix_q;

  ndem_line_ram u_line_ram (
    .clk_i   (clk_i),
    .wr_i    (line_wr),
    .rd_i    (line_rd),
    .rdata_o (line_rdata)
  );

  // Window: two stored columns plus the incoming one (top, middle, bottom)
  ndem_pkg::pix_t [5:0] wcol_q;
  ndem_pkg::pix_t [ndem_pkg::WIN_N-1:0] win;
  logic edge_hit;

  assign win[0] = wcol_q[0];
  assign win[1] = wcol_q[3];
  assign win[2] = line_rdata.upper;
  assign win[3] = wcol_q[1];
  assign win[4] = wcol_q[4];
  assign win[5] = line_rdata.middle;
  assign win[6] = wcol_q[2];
  assign win[7] = wcol_q[5];
  assign win[8] = s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcol_q <= '0;
    end else if (s1_adv) begin
      wcol_q[2:0] <= wcol_q[5:3];
      wcol_q[3]   <= line_rdata.upper;
      wcol_q[4]   <= line_rdata.middle;
      wcol_q[5]   <= s1_pix_q;
    end
  end

  ndem_edge_cmp u_edge_cmp (
    .win_i  (win),
    .thr_i  (thr_q),
    .edge_o (edge_hit)
  );

  // Result register
  logic load_out;
  ndem_pkg::pix_t mark_q;
  logic frame_done_q;

  assign load_out = s1_adv & s1_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      mark_q       <= edge_hit ? ndem_pkg::EDGE_ON : ndem_pkg::EDGE_OFF;
      frame_done_q <= s1_frame_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign edge_mark_o    = mark_q;
  assign frame_done_o   = frame_done_q;

  // Checks
  `ASSERT_PROP(a_frame_wrap, clk_i, rst_ni,
    (in_fire && frame_end) |=> (col_q == '0 && row_q == '0),
    "counters did not wrap at frame end")
  `ASSERT_NEVER(a_ram_same_addr, clk_i, rst_ni,
    line_wr.en && line_rd.en && (line_wr.addr == line_rd.addr),
    "line buffer read and write hit the same column")
  `ASSERT_PROP(a_s1_hold, clk_i, rst_ni,
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_pix_q) && $stable(s1_col_q)),
    "stalled stage 1 item changed")
  `ASSERT_NEVER(a_out_overrun, clk_i, rst_ni,
    load_out && out_valid_q && !result_ready_i,
    "result register overwritten while full")

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the neighbour difference edge marker.
// ----------------------------------------------------------------------------
// Pixels are streamed in raster order with random gaps. Each transfer is fed
// to a behavioural copy of the line buffers and the 3x3 window, which queues
// the expected mark of every interior pixel. Results are taken with random
// back-pressure and compared field by field, in order, against that queue.
// Registers are changed only while the block is idle: at frame boundaries
// and, for height, threshold and a width reduction, in the middle of a frame.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RANDOM_PIXELS = 120;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  // Index with no register behind it; writes there must change nothing
  localparam logic [ndem_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    ndem_pkg::pix_t mark;
    logic           frame_end;
  } mark_t;

  // DUT connections
  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            cfg_we_i       = 1'b0;
  logic [ndem_pkg::CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [ndem_pkg::CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                            pixel_valid_i  = 1'b0;
  logic                            pixel_ready_o;
  ndem_pkg::pix_t                  pixel_i        = '0;
  logic                            result_valid_o;
  logic                            result_ready_i = 1'b0;
  ndem_pkg::pix_t                  edge_mark_o;
  logic                            frame_done_o;

  // Bench state
  mark_t       marks_due[$];
  int unsigned mismatches  = 0;
  int unsigned pixels_sent = 0;
  int unsigned cycle_count = 0;
  bit          pix_held    = 1'b0;
  bit          src_calm    = 1'b0;
  bit          sink_calm   = 1'b0;

  // Behavioural copy of the block state and registers
  ndem_pkg::pix_t upper_row  [ndem_pkg::MAX_WIDTH];
  ndem_pkg::pix_t middle_row [ndem_pkg::MAX_WIDTH];
  ndem_pkg::pix_t win_prev   [6] = '{default: '0};
  int unsigned    col_pos    = 0;
  int unsigned    row_pos    = 0;
  ndem_pkg::dim_t width_reg  = ndem_pkg::RESET_WIDTH;
  ndem_pkg::dim_t height_reg = ndem_pkg::RESET_HEIGHT;
  ndem_pkg::thr_t thr_reg    = ndem_pkg::RESET_THRESHOLD;

  neighbor_difference_edge_marker_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_i        (pixel_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .edge_mark_o    (edge_mark_o),
    .frame_done_o   (frame_done_o)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Effective frame size after clamping
  function automatic int unsigned eff_cols();
    if (width_reg < ndem_pkg::MIN_DIM) return 32'(ndem_pkg::MIN_DIM);
    if (width_reg > ndem_pkg::MAX_WIDTH_DIM) return ndem_pkg::MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_rows();
    if (height_reg < ndem_pkg::MIN_DIM) return 32'(ndem_pkg::MIN_DIM);
    return 32'(height_reg);
  endfunction

  // Advance the line buffers and window by one pixel; queue the mark it gives
  function automatic void step_edge_marker(input ndem_pkg::pix_t px);
    int unsigned    w;
    int unsigned    h;
    ndem_pkg::pix_t top;
    ndem_pkg::pix_t mid;
    ndem_pkg::pix_t diff;
    ndem_pkg::pix_t win [9];
    bit             row_end;
    bit             frame_end;
    bit             edge_found;
    mark_t          due;
    w   = eff_cols();
    h   = eff_rows();
    top = '0;
    mid = '0;
    if (col_pos < ndem_pkg::MAX_WIDTH) begin
      top = upper_row[col_pos];
      mid = middle_row[col_pos];
      upper_row[col_pos]  = mid;
      middle_row[col_pos] = px;
    end
    // rows top/middle/bottom, columns c-2, c-1, c
    win = '{win_prev[0], win_prev[3], top,
            win_prev[1], win_prev[4], mid,
            win_prev[2], win_prev[5], px};
    row_end   = (col_pos + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    if (col_pos >= 2 && row_pos >= 2) begin
      edge_found = 1'b0;
      for (int k = 0; k < ndem_pkg::WIN_N; k++) begin
        diff = (win[k] > win[ndem_pkg::WIN_CTR]) ? win[k] - win[ndem_pkg::WIN_CTR] :
                                                   win[ndem_pkg::WIN_CTR] - win[k];
        if (k != ndem_pkg::WIN_CTR && diff > thr_reg) edge_found = 1'b1;
      end
      due.mark      = edge_found ? ndem_pkg::EDGE_ON : ndem_pkg::EDGE_OFF;
      due.frame_end = frame_end;
      marks_due.push_back(due);
    end
    win_prev = '{win_prev[3], win_prev[4], win_prev[5], top, mid, px};
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : ((row_pos + 1) & 12'hFFF);
    end else begin
      col_pos = (col_pos + 1) & 11'h7FF;
    end
  endfunction

  // Pixel around a base value, clipped to the 8-bit range
  function automatic ndem_pkg::pix_t scatter_pixel(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(0, spread)) - spread / 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ndem_pkg::pix_t'(v);
  endfunction

  // Mostly flat picture with steps of exactly 100 and 101
  function automatic ndem_pkg::pix_t threshold_probe_pixel();
    case ($urandom_range(0, 19))
      16:      return 8'd0;
      17:      return 8'd200;
      18:      return 8'd101;
      19:      return 8'd201;
      default: return 8'd100;
    endcase
  endfunction

  // One pixel transfer, after a random gap
  task automatic push_pixel(input ndem_pkg::pix_t px);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      if (pix_held) pixel_valid_i <= 1'b0;
      pix_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pixel_i       <= px;
    pixel_valid_i <= 1'b1;
    pix_held = 1'b1;
    do @(posedge clk_i); while (!pixel_ready_o);
    step_edge_marker(px);
    pixels_sent++;
  endtask

  // Stop sending, let every expected mark arrive and the pipeline empty
  task automatic wait_drain();
    if (pix_held) pixel_valid_i <= 1'b0;
    pix_held = 1'b0;
    do @(posedge clk_i); while (marks_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ndem_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ndem_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      ndem_pkg::REG_IMAGE_WIDTH:    width_reg  = val;
      ndem_pkg::REG_IMAGE_HEIGHT:   height_reg = val;
      ndem_pkg::REG_DIFF_THRESHOLD: thr_reg    = val[ndem_pkg::THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_frame(input int base, input int spread);
    int unsigned n;
    n = eff_cols() * eff_rows();
    repeat (n) push_pixel(scatter_pixel(base, spread));
  endtask

  // Reset register values: 640 wide, threshold 100, then a narrowing width
  // in the middle of a row and a height far below 480
  task automatic test_reset_values();
    repeat (2 * 640 + 8) push_pixel(threshold_probe_pixel());
    wait_drain();
    write_reg(ndem_pkg::REG_IMAGE_WIDTH, 12'd4);
    write_reg(ndem_pkg::REG_IMAGE_HEIGHT, 12'd6);
    // column 8 now closes row 2, rows 3 to 5 follow at width 4
    repeat (1 + 3 * 4) push_pixel(threshold_probe_pixel());
    wait_drain();
  endtask

  // Clamped sizes, pixel extremes and the threshold extremes
  task automatic test_corner_pixels();
    ndem_pkg::pix_t hot_corner [9] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                       8'd255};
    ndem_pkg::pix_t dark_centre[9] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
                                       8'd255, 8'd255, 8'd255, 8'd255};
    ndem_pkg::pix_t one_step   [9] = '{8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77,
                                       8'd78, 8'd77};
    write_reg(ndem_pkg::REG_IMAGE_WIDTH, 12'd0);
    write_reg(ndem_pkg::REG_IMAGE_HEIGHT, 12'd2);
    write_reg(ndem_pkg::REG_DIFF_THRESHOLD, 12'hAFE);
    write_reg(REG_SPARE, 12'hFFF);
    foreach (hot_corner[i]) push_pixel(hot_corner[i]);
    wait_drain();
    write_reg(ndem_pkg::REG_DIFF_THRESHOLD, 12'h0FF);
    foreach (dark_centre[i]) push_pixel(dark_centre[i]);
    wait_drain();
    write_reg(ndem_pkg::REG_DIFF_THRESHOLD, 12'h000);
    foreach (one_step[i]) push_pixel(one_step[i]);
    wait_drain();
  endtask

  // Height and threshold rewritten part way through a frame
  task automatic test_mid_frame_changes();
    write_reg(ndem_pkg::REG_IMAGE_WIDTH, 12'd5);
    write_reg(ndem_pkg::REG_IMAGE_HEIGHT, 12'd12);
    write_reg(ndem_pkg::REG_DIFF_THRESHOLD, 12'd20);
    repeat (4 * 5) push_pixel(scatter_pixel(128, 64));
    wait_drain();
    write_reg(ndem_pkg::REG_DIFF_THRESHOLD, 12'd200);
    write_reg(ndem_pkg::REG_IMAGE_HEIGHT, 12'd6);
    repeat (2 * 5) push_pixel(scatter_pixel(128, 255));
    wait_drain();
    write_reg(ndem_pkg::REG_IMAGE_WIDTH, 12'd7);
    write_reg(ndem_pkg::REG_IMAGE_HEIGHT, 12'd12);
    write_reg(ndem_pkg::REG_DIFF_THRESHOLD, 12'd30);
    repeat (6 * 7) push_pixel(scatter_pixel(90, 64));
    wait_drain();
    // height already passed: the current row ends the frame
    write_reg(ndem_pkg::REG_IMAGE_HEIGHT, 12'd3);
    repeat (7) push_pixel(scatter_pixel(90, 64));
    wait_drain();
  endtask

  // Whole frames of random size, threshold and texture
  task automatic test_random_frames();
    int unsigned                     goal;
    int                              spread;
    logic [ndem_pkg::CFG_DATA_W-1:0] w_val;
    logic [ndem_pkg::CFG_DATA_W-1:0] h_val;
    ndem_pkg::thr_t                  thr;
    goal = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < goal) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 19))
          0:       w_val = ndem_pkg::CFG_DATA_W'($urandom_range(0, 2));
          1, 2, 3: w_val = ndem_pkg::CFG_DATA_W'($urandom_range(13, 40));
          default: w_val = ndem_pkg::CFG_DATA_W'($urandom_range(3, 12));
        endcase
        case ($urandom_range(0, 19))
          0:       h_val = ndem_pkg::CFG_DATA_W'($urandom_range(0, 2));
          1, 2:    h_val = ndem_pkg::CFG_DATA_W'($urandom_range(9, 20));
          default: h_val = ndem_pkg::CFG_DATA_W'($urandom_range(3, 8));
        endcase
        case ($urandom_range(0, 9))
          0:          thr = 8'd0;
          1:          thr = 8'd255;
          2, 3, 4, 5: thr = ndem_pkg::THR_W'($urandom_range(0, 255));
          default:    thr = ndem_pkg::THR_W'($urandom_range(0, 40));
        endcase
        wait_drain();
        write_reg(ndem_pkg::REG_IMAGE_WIDTH, w_val);
        write_reg(ndem_pkg::REG_IMAGE_HEIGHT, h_val);
        write_reg(ndem_pkg::REG_DIFF_THRESHOLD, {4'($urandom_range(0, 15)), thr});
      end
      case ($urandom_range(0, 4))
        0:       spread = 0;
        1:       spread = 4;
        2:       spread = 24;
        3:       spread = 64;
        default: spread = 255;
      endcase
      send_frame($urandom_range(0, 255), spread);
    end
    wait_drain();
  endtask

  // A wide three-row band and a tall narrow frame
  task automatic test_long_frames();
    write_reg(ndem_pkg::REG_IMAGE_WIDTH, 12'd40);
    write_reg(ndem_pkg::REG_IMAGE_HEIGHT, 12'd3);
    write_reg(ndem_pkg::REG_DIFF_THRESHOLD, 12'd32);
    send_frame(128, 64);
    wait_drain();
    write_reg(ndem_pkg::REG_IMAGE_WIDTH, 12'd3);
    write_reg(ndem_pkg::REG_IMAGE_HEIGHT, 12'd30);
    send_frame(128, 64);
    wait_drain();
  endtask

  // Quiet spells for both sides now and then
  always begin : calm_toggle
    repeat ($urandom_range(50, 400)) @(posedge clk_i);
    src_calm  <= ($urandom_range(0, 3) == 0);
    sink_calm <= ($urandom_range(0, 3) == 0);
  end

  // Result sink with a random stall before each transfer
  always begin : result_sink
    int unsigned hold;
    hold = sink_calm ? 0 : $urandom_range(0, 10);
    if (hold != 0) begin
      result_ready_i <= 1'b0;
      repeat (hold) @(posedge clk_i);
    end
    result_ready_i <= 1'b1;
    do @(posedge clk_i); while (!(result_valid_o === 1'b1 && result_ready_i));
  end

  // Compare each result transfer with the oldest expected mark
  always @(posedge clk_i) begin : mark_check
    mark_t want;
    if (rst_ni && result_valid_o === 1'b1 && result_ready_i) begin
      if (marks_due.size() == 0) begin
        $display("%0t: unexpected result, edge_mark %0d frame_done %0b",
                 $time, edge_mark_o, frame_done_o);
        mismatches++;
      end else begin
        want = marks_due.pop_front();
        if (edge_mark_o !== want.mark) begin
          $display("%0t: edge_mark expected %0d actual %0d",
                   $time, want.mark, edge_mark_o);
          mismatches++;
        end
        if (frame_done_o !== want.frame_end) begin
          $display("%0t: frame_done expected %0b actual %0b",
                   $time, want.frame_end, frame_done_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout, %0d marks outstanding", $time, marks_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Test sequence
  initial begin : main
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_corner_pixels();
    test_mid_frame_changes();
    test_random_frames();
    test_long_frames();
    wait_drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ndem_pkg.sv
rtl/ndem_line_ram.sv
rtl/ndem_edge_cmp.sv
rtl/neighbor_difference_edge_marker_top.sv
tb/sv/testbench.sv
